### rtl/iee_pkg.sv
// Shared types, codes and helpers of the infix expression evaluator.
package iee_pkg;

    // Operator stack codes
    localparam logic [2:0] OPC_ADD   = 3'd0;
    localparam logic [2:0] OPC_SUB   = 3'd1;
    localparam logic [2:0] OPC_MUL   = 3'd2;
    localparam logic [2:0] OPC_DIV   = 3'd3;
    localparam logic [2:0] OPC_PAREN = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_STACK   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Character codes
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Divider iterations for a 32-bit quotient
    localparam logic [5:0] DIV_STEPS = 6'd32;

    // Reduction loop that is being run
    typedef enum logic [1:0] {
        M_OP    = 2'd0,
        M_CLOSE = 2'd1,
        M_FINAL = 2'd2
    } t_mode;

    // Commands from controller to datapath
    typedef struct packed {
        logic       load;
        logic       digit;
        logic       flush;
        logic       push_paren;
        logic       push_op;
        logic       pop_paren;
        logic       fetch;
        logic       alu;
        logic       div_start;
        logic       wb;
        logic       flag_en;
        logic [1:0] flag_code;
        logic       emit;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic       err;
        logic       last;
        logic       is_digit;
        logic       is_space;
        logic       is_lpar;
        logic       is_rpar;
        logic       is_op;
        logic       op_empty;
        logic       top_paren;
        logic       rank_ge;
        logic       cnt_lt2;
        logic [2:0] top_opc;
        logic       b_zero;
        logic       div_done;
        logic       out_free;
    } t_stat;

    // Precedence rank of an operator code
    function automatic logic [1:0] rank(input logic [2:0] opc);
        logic [1:0] r;
        r = 2'd0;
        if (opc == OPC_ADD || opc == OPC_SUB) r = 2'd1;
        if (opc == OPC_MUL || opc == OPC_DIV) r = 2'd2;
        return r;
    endfunction

endpackage

### rtl/iee_ctrl.sv
// Sequencing state machine of the infix expression evaluator.
module iee_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  iee_pkg::t_stat i_st,
    output iee_pkg::t_cmd  o_cmd,
    output logic          o_stall
);
    import iee_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_CHAR   = 11'b00000000010,
        S_CLASS  = 11'b00000000100,
        S_FETCH  = 11'b00000001000,
        S_LOOK   = 11'b00000010000,
        S_REDUCE = 11'b00000100000,
        S_DIV    = 11'b00001000000,
        S_WB     = 11'b00010000000,
        S_END    = 11'b00100000000,
        S_FFLUSH = 11'b01000000000,
        S_EMIT   = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    t_mode  r_mode, n_mode;

    // Hold state and loop mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode  <= M_OP;
        end else begin
            r_state <= n_state;
            r_mode  <= n_mode;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_mode  = r_mode;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHAR;
                end
            end
            S_CHAR: begin
                if (i_st.err) begin
                    n_state = S_END;
                end else if (i_st.is_digit) begin
                    o_cmd.digit = 1'b1;
                    n_state     = S_END;
                end else begin
                    o_cmd.flush = 1'b1;
                    n_state     = S_CLASS;
                end
            end
            S_CLASS: begin
                n_state = S_END;
                if (i_st.err || i_st.is_space) begin
                    n_state = S_END;
                end else if (i_st.is_lpar) begin
                    o_cmd.push_paren = 1'b1;
                end else if (i_st.is_rpar) begin
                    n_mode  = M_CLOSE;
                    n_state = S_FETCH;
                end else if (i_st.is_op) begin
                    n_mode  = M_OP;
                    n_state = S_FETCH;
                end else begin
                    o_cmd.flag_en   = 1'b1;
                    o_cmd.flag_code = ST_UNKNOWN;
                end
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_LOOK;
            end
            S_LOOK: begin
                case (r_mode)
                    M_CLOSE: begin
                        n_state = S_END;
                        if (!i_st.err) begin
                            if (i_st.op_empty) begin
                                o_cmd.flag_en   = 1'b1;
                                o_cmd.flag_code = ST_STACK;
                            end else if (i_st.top_paren) begin
                                o_cmd.pop_paren = 1'b1;
                            end else begin
                                n_state = S_REDUCE;
                            end
                        end
                    end
                    M_FINAL: begin
                        n_state = S_EMIT;
                        if (!i_st.err && !i_st.op_empty) begin
                            if (i_st.top_paren) begin
                                o_cmd.flag_en   = 1'b1;
                                o_cmd.flag_code = ST_STACK;
                            end else begin
                                n_state = S_REDUCE;
                            end
                        end
                    end
                    default: begin
                        n_state = S_END;
                        if (!i_st.err) begin
                            if (!i_st.op_empty && i_st.rank_ge) begin
                                n_state = S_REDUCE;
                            end else begin
                                o_cmd.push_op = 1'b1;
                            end
                        end
                    end
                endcase
            end
            S_REDUCE: begin
                n_state = S_FETCH;
                if (i_st.cnt_lt2) begin
                    o_cmd.flag_en   = 1'b1;
                    o_cmd.flag_code = ST_STACK;
                end else begin
                    case (i_st.top_opc) inside
                        OPC_ADD, OPC_SUB, OPC_MUL: begin
                            o_cmd.alu = 1'b1;
                            n_state   = S_WB;
                        end
                        OPC_DIV: begin
                            if (i_st.b_zero) begin
                                o_cmd.flag_en   = 1'b1;
                                o_cmd.flag_code = ST_DIVZERO;
                            end else begin
                                o_cmd.div_start = 1'b1;
                                n_state         = S_DIV;
                            end
                        end
                        default: begin
                            o_cmd.flag_en   = 1'b1;
                            o_cmd.flag_code = ST_STACK;
                        end
                    endcase
                end
            end
            S_DIV: begin
                if (i_st.div_done) n_state = S_WB;
            end
            S_WB: begin
                o_cmd.wb = 1'b1;
                n_state  = S_FETCH;
            end
            S_END: begin
                if (!i_st.last) begin
                    n_state = S_IDLE;
                end else if (i_st.err) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_FFLUSH;
                end
            end
            S_FFLUSH: begin
                o_cmd.flush = 1'b1;
                n_mode      = M_FINAL;
                n_state     = S_FETCH;
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

### rtl/iee_dp.sv
// Stacks, number accumulator, arithmetic unit and output register.
module iee_dp #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  iee_pkg::t_cmd       i_cmd,
    input  logic [7:0]          i_char_code,
    input  logic                i_last_char,
    input  logic                i_stall,
    output iee_pkg::t_stat      o_st,
    output logic                o_valid,
    output logic signed [31:0]  o_result_value,
    output logic [1:0]          o_status
);
    import iee_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

    logic [31:0]   opnd_mem [STACK_DEPTH];
    logic [2:0]    oper_mem [STACK_DEPTH];

    logic [7:0]    r_char;
    logic          r_last;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_opcnt, n_opcnt;
    logic [31:0]   r_acc, n_acc;
    logic          r_pend, n_pend;
    logic [1:0]    r_err, n_err;
    logic [31:0]   r_rd_a, r_rd_b, r_res;
    logic [2:0]    r_rd_op;
    logic [31:0]   r_dvd, r_dvs, r_rem;
    logic [5:0]    r_dcnt;
    logic          r_dneg, r_dbusy;

    logic [2:0]    cur_opc;
    logic          is_op;
    logic [CW-1:0] cnt_m1, cnt_m2, opcnt_m1;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [31:0]   wr_data;
    logic          opw_en;
    logic [2:0]    opw_data;
    logic [32:0]   rem_sh, rem_sub;
    logic [1:0]    out_status;

    assign cnt_m1   = r_cnt - CW'(1);
    assign cnt_m2   = r_cnt - CW'(2);
    assign opcnt_m1 = r_opcnt - CW'(1);

    // Decode the held character
    always_comb begin
        is_op   = 1'b1;
        cur_opc = OPC_ADD;
        case (r_char)
            CH_PLUS:  cur_opc = OPC_ADD;
            CH_MINUS: cur_opc = OPC_SUB;
            CH_STAR:  cur_opc = OPC_MUL;
            CH_SLASH: cur_opc = OPC_DIV;
            default:  is_op   = 1'b0;
        endcase
    end

    assign o_st.err       = (r_err != ST_OK);
    assign o_st.last      = r_last;
    assign o_st.is_digit  = (r_char >= CH_ZERO) && (r_char <= CH_NINE);
    assign o_st.is_space  = (r_char == CH_SPACE);
    assign o_st.is_lpar   = (r_char == CH_LPAR);
    assign o_st.is_rpar   = (r_char == CH_RPAR);
    assign o_st.is_op     = is_op;
    assign o_st.op_empty  = (r_opcnt == '0);
    assign o_st.top_paren = (r_rd_op == OPC_PAREN);
    assign o_st.rank_ge   = (rank(r_rd_op) >= rank(cur_opc));
    assign o_st.cnt_lt2   = (r_cnt < CW'(2));
    assign o_st.top_opc   = r_rd_op;
    assign o_st.b_zero    = (r_rd_b == '0);
    assign o_st.div_done  = r_dbusy && (r_dcnt == '0);
    assign o_st.out_free  = !o_valid || !i_stall;

    // Work out stack and scalar updates
    always_comb begin
        n_cnt    = r_cnt;
        n_opcnt  = r_opcnt;
        n_acc    = r_acc;
        n_pend   = r_pend;
        n_err    = r_err;
        wr_en    = 1'b0;
        wr_addr  = r_cnt[AW-1:0];
        wr_data  = r_acc;
        opw_en   = 1'b0;
        opw_data = OPC_PAREN;
        if (i_cmd.digit) begin
            n_acc  = (r_acc << 3) + (r_acc << 1) + {28'd0, r_char[3:0] - CH_ZERO[3:0]};
            n_pend = 1'b1;
        end
        if (i_cmd.flush && r_pend) begin
            n_acc  = '0;
            n_pend = 1'b0;
            if (r_cnt == FULL) begin
                if (r_err == ST_OK) n_err = ST_STACK;
            end else begin
                wr_en = 1'b1;
                n_cnt = r_cnt + CW'(1);
            end
        end
        if (i_cmd.push_paren || i_cmd.push_op) begin
            opw_data = i_cmd.push_op ? cur_opc : OPC_PAREN;
            if (r_opcnt == FULL) begin
                if (r_err == ST_OK) n_err = ST_STACK;
            end else begin
                opw_en  = 1'b1;
                n_opcnt = r_opcnt + CW'(1);
            end
        end
        if (i_cmd.pop_paren) n_opcnt = opcnt_m1;
        if (i_cmd.wb) begin
            wr_en   = 1'b1;
            wr_addr = cnt_m2[AW-1:0];
            wr_data = r_res;
            n_cnt   = cnt_m1;
            n_opcnt = opcnt_m1;
        end
        if (i_cmd.flag_en && r_err == ST_OK) n_err = i_cmd.flag_code;
        if (i_cmd.emit) begin
            n_cnt   = '0;
            n_opcnt = '0;
            n_acc   = '0;
            n_pend  = 1'b0;
            n_err   = ST_OK;
        end
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_opcnt <= '0;
            r_acc   <= '0;
            r_pend  <= 1'b0;
            r_err   <= ST_OK;
            r_dbusy <= 1'b0;
            r_dcnt  <= '0;
            o_valid <= 1'b0;
        end else begin
            r_cnt   <= n_cnt;
            r_opcnt <= n_opcnt;
            r_acc   <= n_acc;
            r_pend  <= n_pend;
            r_err   <= n_err;
            if (i_cmd.div_start) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= DIV_STEPS;
            end else if (r_dbusy) begin
                if (r_dcnt == '0) r_dbusy <= 1'b0;
                else r_dcnt <= r_dcnt - 6'd1;
            end
            if (i_cmd.emit) o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
        end
    end

    // Stack memories
    always_ff @(posedge i_clk) begin
        if (wr_en) opnd_mem[wr_addr] <= wr_data;
        if (opw_en) oper_mem[r_opcnt[AW-1:0]] <= opw_data;
        if (i_cmd.fetch) begin
            r_rd_b  <= opnd_mem[cnt_m1[AW-1:0]];
            r_rd_a  <= opnd_mem[cnt_m2[AW-1:0]];
            r_rd_op <= oper_mem[opcnt_m1[AW-1:0]];
        end
    end

    // Restoring divider step on magnitudes
    assign rem_sh  = {r_rem, r_dvd[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    // Arithmetic and divider registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_char <= i_char_code;
            r_last <= i_last_char;
        end
        if (i_cmd.alu) begin
            case (r_rd_op)
                OPC_ADD: r_res <= r_rd_a + r_rd_b;
                OPC_SUB: r_res <= r_rd_a - r_rd_b;
                default: r_res <= r_rd_a * r_rd_b;
            endcase
        end
        if (i_cmd.div_start) begin
            r_dvd  <= r_rd_a[31] ? (32'd0 - r_rd_a) : r_rd_a;
            r_dvs  <= r_rd_b[31] ? (32'd0 - r_rd_b) : r_rd_b;
            r_rem  <= '0;
            r_dneg <= r_rd_a[31] ^ r_rd_b[31];
        end else if (r_dbusy) begin
            if (r_dcnt == '0) begin
                r_res <= r_dneg ? (32'd0 - r_dvd) : r_dvd;
            end else if (!rem_sub[32]) begin
                r_rem <= rem_sub[31:0];
                r_dvd <= {r_dvd[30:0], 1'b1};
            end else begin
                r_rem <= rem_sh[31:0];
                r_dvd <= {r_dvd[30:0], 1'b0};
            end
        end
    end

    // Result status: leftover operands count as a stack fault
    assign out_status = (r_err != ST_OK) ? r_err :
                        ((r_cnt != CW'(1)) ? ST_STACK : ST_OK);

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_status       <= out_status;
            o_result_value <= (out_status == ST_OK) ? r_rd_b : 32'sd0;
        end
    end

endmodule

### rtl/infix_expression_evaluator.sv
// Top level of the infix expression evaluator: controller plus datapath.
// One ASCII character is taken per transfer; o_stall stays high while the
// character is worked on. A digit is only accumulated; any other character first
// pushes a pending number, and an operator or ')' then runs the reduction loop
// (a division runs the bit-serial divider). The transfer marked last then runs
// the final reductions before the result (skipped when an error is already
// held), and waits further while the previous result is still stalled. Each step
// of the reduction loop reads the stack memories through a registered read port.
// One result per expression, status 0 ok, 1 divide by zero, 2 stack fault, 3
// unknown character; the value is 0 on any error. No clearing pass is needed
// after reset.
module infix_expression_evaluator #(
    parameter int STACK_DEPTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_char,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_result_value,
    output logic [1:0]         o_status
);
    import iee_pkg::*;

    t_cmd  cmd;
    t_stat st;

    iee_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_st    (st),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    iee_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .i_stall        (i_stall),
        .o_st           (st),
        .o_valid        (o_valid),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

endmodule

### rtl/iee_chk.sv
// Port-level checks of the infix expression evaluator and their binding.
module iee_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_result_value,
    input logic [1:0]         o_status
);
    import iee_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_value) && $stable(o_status))
        else $error("stalled result changed");

    // Drop the value on an error
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status != ST_OK) |-> (o_result_value == 32'sd0))
        else $error("error result carries a value");

    // Stall after each accepted transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("no busy cycle after a transfer");

    // Clear the output on reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind infix_expression_evaluator iee_chk u_iee_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_value (o_result_value),
    .o_status       (o_status)
);

### test/infix_expression_evaluator_tb.sv
// Self-checking testbench of the infix expression evaluator.
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;
    import iee_pkg::*;

    localparam int DEPTH      = 32;
    localparam int CYCLE_CAP  = 2000000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [7:0]         i_char_code;
    logic               i_last_char;
    logic               o_valid;
    logic               i_stall;
    logic signed [31:0] o_result_value;
    logic [1:0]         o_status;

    infix_expression_evaluator #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_char_code    (i_char_code),
        .i_last_char    (i_last_char),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_result_value (o_result_value),
        .o_status       (o_status)
    );

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  status;
    } t_outcome;

    // Evaluator state mirrored by the predictor
    logic [31:0] val_stk [DEPTH];
    logic [2:0]  opr_stk [DEPTH];
    int          val_cnt;
    int          opr_cnt;
    logic [31:0] num_acc;
    logic        num_pend;
    logic [1:0]  err;

    t_outcome    outcome_q[$];
    int          mismatches;
    int          cycle_cnt;
    int          send_idle_pct;
    int          recv_idle_pct;

    // Directed rows: character string, expected value/status when obvious
    typedef struct {
        string       text;
        logic        known;
        logic [31:0] value;
        logic [1:0]  status;
    } t_row;

    t_row rows[$];

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_CAP) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h, expected %0h at cycle %0d",
                 what, got, want, cycle_cnt);
        mismatches++;
    endtask

    function automatic void clear_state();
        val_cnt  = 0;
        opr_cnt  = 0;
        num_acc  = '0;
        num_pend = 1'b0;
        err      = ST_OK;
    endfunction

    function automatic void raise(input logic [1:0] code);
        if (err == ST_OK) err = code;
    endfunction

    function automatic logic [1:0] prec(input logic [2:0] opc);
        if (opc == OPC_ADD || opc == OPC_SUB) return 2'd1;
        if (opc == OPC_MUL || opc == OPC_DIV) return 2'd2;
        return 2'd0;
    endfunction

    function automatic void push_val(input logic [31:0] v);
        if (val_cnt >= DEPTH) begin
            raise(ST_STACK);
            return;
        end
        val_stk[val_cnt] = v;
        val_cnt++;
    endfunction

    function automatic void push_opr(input logic [2:0] opc);
        if (opr_cnt >= DEPTH) begin
            raise(ST_STACK);
            return;
        end
        opr_stk[opr_cnt] = opc;
        opr_cnt++;
    endfunction

    function automatic void apply_top();
        logic [2:0]  opc;
        logic [31:0] a, b, r, ma, mb, q;
        if (opr_cnt == 0 || val_cnt < 2) begin
            raise(ST_STACK);
            return;
        end
        opc = opr_stk[opr_cnt-1];
        b = val_stk[val_cnt-1];
        a = val_stk[val_cnt-2];
        case (opc)
            OPC_ADD: r = a + b;
            OPC_SUB: r = a - b;
            OPC_MUL: r = a * b;
            OPC_DIV: begin
                if (b == 0) begin
                    raise(ST_DIVZERO);
                    return;
                end
                ma = a[31] ? -a : a;
                mb = b[31] ? -b : b;
                q = ma / mb;
                r = (a[31] != b[31]) ? -q : q;
            end
            default: begin
                raise(ST_STACK);
                return;
            end
        endcase
        opr_cnt--;
        val_cnt--;
        val_stk[val_cnt-1] = r;
    endfunction

    function automatic void flush_num();
        if (num_pend) begin
            push_val(num_acc);
            num_acc  = '0;
            num_pend = 1'b0;
        end
    endfunction

    function automatic void consume_char(input logic [7:0] c);
        logic [2:0] opc;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            num_acc  = num_acc * 10 + 32'(c - CH_ZERO);
            num_pend = 1'b1;
            return;
        end
        flush_num();
        if (err != ST_OK || c == CH_SPACE) return;
        if (c == CH_LPAR) begin
            push_opr(OPC_PAREN);
            return;
        end
        if (c == CH_RPAR) begin
            while (err == ST_OK && opr_cnt > 0 && opr_stk[opr_cnt-1] != OPC_PAREN)
                apply_top();
            if (err != ST_OK) return;
            if (opr_cnt == 0) begin
                raise(ST_STACK);
                return;
            end
            opr_cnt--;
            return;
        end
        case (c)
            CH_PLUS:  opc = OPC_ADD;
            CH_MINUS: opc = OPC_SUB;
            CH_STAR:  opc = OPC_MUL;
            CH_SLASH: opc = OPC_DIV;
            default: begin
                raise(ST_UNKNOWN);
                return;
            end
        endcase
        while (err == ST_OK && opr_cnt > 0 && prec(opr_stk[opr_cnt-1]) >= prec(opc))
            apply_top();
        if (err == ST_OK) push_opr(opc);
    endfunction

    // Predict the outcome of one character; queue it when the expression ends
    function automatic void evaluate_char(input logic [7:0] c, input logic last);
        t_outcome o;
        if (err == ST_OK) consume_char(c);
        if (!last) return;
        if (err == ST_OK) flush_num();
        while (err == ST_OK && opr_cnt > 0) begin
            if (opr_stk[opr_cnt-1] == OPC_PAREN) raise(ST_STACK);
            else apply_top();
        end
        if (err == ST_OK && val_cnt != 1) raise(ST_STACK);
        o.value  = (err == ST_OK) ? val_stk[0] : '0;
        o.status = err;
        outcome_q.push_back(o);
        clear_state();
    endfunction

    // Send one character and wait for its transfer
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_char_code <= c;
        i_last_char <= last;
        evaluate_char(c, last);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++)
            send_char(s[k], k == s.len() - 1);
    endtask

    // Receiver side: random stall and checking
    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_valid && !i_stall) begin
            if (outcome_q.size() == 0) begin
                $display("unexpected result %0h/%0d", o_result_value, o_status);
                mismatches++;
            end else begin
                w = outcome_q.pop_front();
                if (o_result_value !== w.value)
                    report_mismatch("value", o_result_value, w.value);
                if (o_status !== w.status)
                    report_mismatch("status", 32'(o_status), 32'(w.status));
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic string rand_number();
        string s;
        int    n;
        s = "";
        n = ($urandom_range(9) == 0) ? $urandom_range(12, 10) : $urandom_range(3, 1);
        for (int k = 0; k < n; k++)
            s = {s, string'(8'(CH_ZERO + $urandom_range(9)))};
        return s;
    endfunction

    function automatic string rand_op();
        case ($urandom_range(3))
            0: return "+";
            1: return "-";
            2: return "*";
            default: return "/";
        endcase
    endfunction

    // Build a well formed expression of bounded nesting
    function automatic string rand_expr(input int lvl);
        string s;
        int    terms;
        terms = $urandom_range(3, 1);
        s = "";
        for (int k = 0; k < terms; k++) begin
            if (k > 0) s = {s, ($urandom_range(3) == 0) ? " " : "", rand_op()};
            if (lvl > 0 && $urandom_range(3) == 0) s = {s, "(", rand_expr(lvl - 1), ")"};
            else s = {s, rand_number()};
        end
        return s;
    endfunction

    // Damage an expression: replace one character at random
    function automatic string corrupt(input string s);
        int p;
        p = $urandom_range(s.len() - 1);
        s[p] = ($urandom_range(1) == 0) ? 8'($urandom_range(255))
                                        : ($urandom_range(1) ? CH_LPAR : CH_RPAR);
        return s;
    endfunction

    task automatic drain();
        i_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic void add_row(input string s, input logic known,
                                    input logic [31:0] v, input logic [1:0] st);
        t_row r;
        r.text = s; r.known = known; r.value = v; r.status = st;
        rows.push_back(r);
    endfunction

    initial begin
        string s;
        int    sent;
        logic  [7:0] c;
        i_rst_n = 1'b0; i_valid = 1'b0; i_char_code = '0; i_last_char = 1'b0;
        i_stall = 1'b0;
        mismatches = 0; cycle_cnt = 0;
        send_idle_pct = 23; recv_idle_pct = 62;
        clear_state();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        add_row("7", 1, 7, ST_OK);
        add_row("2147483647", 1, 32'h7FFF_FFFF, ST_OK);
        add_row("4294967296", 1, 0, ST_OK);
        add_row("1+2*3", 1, 7, ST_OK);
        add_row("(1+2)*3", 1, 9, ST_OK);
        add_row("8-10", 1, 32'hFFFF_FFFE, ST_OK);
        add_row("0-7/2", 1, 32'hFFFF_FFFD, ST_OK);
        add_row("5/0", 1, 0, ST_DIVZERO);
        add_row("0-2147483648/(0-1)", 0, 0, ST_OK);
        add_row("3%2", 1, 0, ST_UNKNOWN);
        add_row("2+", 1, 0, ST_STACK);
        add_row("1)", 1, 0, ST_STACK);
        add_row("(1", 1, 0, ST_STACK);
        add_row("1 2", 1, 0, ST_STACK);
        add_row(" ", 1, 0, ST_STACK);
        add_row("(((((((((((((((((((((((((((((((((1", 1, 0, ST_STACK);
        add_row("65535*65537 - 9 / 3", 0, 0, ST_OK);
        for (int k = 0; k < rows.size(); k++) begin
            send_text(rows[k].text);
            if (rows[k].known &&
                (outcome_q[$].value !== rows[k].value ||
                 outcome_q[$].status !== rows[k].status))
                report_mismatch({"row ", rows[k].text}, outcome_q[$].value,
                                rows[k].value);
        end
        // Wait for every result before random traffic
        drain();

        // Random part in three idling phases
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 62 : 0;
            recv_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 23 : 0;
            sent = 0;
            while (sent < 420) begin
                case ($urandom_range(9))
                    0: begin
                        s = "";
                        for (int k = $urandom_range(6, 1); k > 0; k--) begin
                            c = 8'($urandom_range(255));
                            s = {s, string'(c)};
                        end
                    end
                    1: s = corrupt(rand_expr(2));
                    default: s = rand_expr(3);
                endcase
                if (s.len() == 0) s = "0";
                send_text(s);
                sent += s.len();
            end
            drain();
        end

        if (mismatches == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule
